>>> sv/svap_pkg.sv
// shared types and constants for the sound voice allocator and panner
// no dependencies; used by svap_ctrl, svap_dp and the top level
`timescale 1ns / 1ps

package svap_pkg;

    typedef enum logic [1:0] {
        REQ_PLAY = 2'd0,
        REQ_KEY  = 2'd1,
        REQ_PAN  = 2'd2,
        REQ_MUTE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_NOT_FND  = 2'd2,
        ST_NO_ACT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KS_OFF         = 2'd0,
        KS_ON          = 2'd1,
        KS_ON_ENV_OFF  = 2'd2,
        KS_OFF_ENV_ON  = 2'd3
    } t_key_state;

    typedef enum logic [1:0] {
        REG_SFX_VOL = 2'd0,
        REG_SWAP    = 2'd1,
        REG_REVERB  = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE1,
        OP_SCALE2,
        OP_SCAN,
        OP_LEVEL,
        OP_SQ,
        OP_ROOT,
        OP_PAN,
        OP_MUL,
        OP_DIV,
        OP_FINISH
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCALE1,
        S_SCALE2,
        S_SCAN,
        S_LEVEL,
        S_SQ,
        S_ROOT,
        S_PAN,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic bad;
        logic match;
        logic scan_last;
        logic p_zero;
    } t_stat;

    localparam logic [3:0]  SFX_VOL_MAX = 4'd12;
    localparam logic [3:0]  SFX_VOL_RST = 4'd12;
    // floor(x/12) == (x * RECIP12) >> RECIP_SH for x below 2^19
    localparam logic [35:0] RECIP12     = 36'd174763;
    localparam int          RECIP_SH    = 21;
    localparam logic [31:0] ROOT_BIT0   = 32'h4000_0000;
    localparam logic [15:0] TAG_LOW     = 16'h8000;
    localparam logic [4:0]  SQ_STEPS    = 5'd3;
    localparam logic [4:0]  ROOT_STEPS  = 5'd16;
    localparam logic [4:0]  DIV_STEPS   = 5'd30;

endpackage

>>> sv/sound_voice_allocator_panner.sv
// Sound voice allocator and panner. Raise start while busy is low; each item gives one
// result, marked by o_valid for exactly one cycle. The receiver cannot stall it and must
// take it then. From the accepting edge a play item keeps busy high through dispatch,
// 2 steps to scale the volume, 3 to sum squares, 16 for the bit-pair square root, pan
// and multiply steps, 30 for the restoring divider and finish. Its result is registered
// from the finish step. A zero pan magnitude skips the divider. A pan update scans
// the tags at one voice per cycle, up to NUM_VOICES, and reads the stored level. It then
// runs the same square, root and divide steps. A mute only scans, and a key report or a
// rejected play goes from dispatch straight to finish. Config via APB anytime idle.
// top level: joins svap_ctrl and svap_dp; depends on svap_pkg
`timescale 1ns / 1ps

module sound_voice_allocator_panner #(
    parameter int NUM_VOICES  = 24,
    parameter int NUM_EFFECTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [1:0]  i_req_type,
    input  logic [6:0]  i_sfx_index,
    input  logic [15:0] i_tag,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [15:0] i_dir_z,
    input  logic [13:0] i_base_volume,
    input  logic [4:0]  i_voice_in,
    input  logic [1:0]  i_key_state,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [4:0]  o_voice_out,
    output logic [14:0] o_vol_left,
    output logic [14:0] o_vol_right,
    output logic        o_vol_valid,
    output logic        o_key_on,
    output logic        o_key_off,
    output logic        o_reverb_on,
    output logic        o_note_down,
    output logic [6:0]  o_sfx_out
);

    svap_pkg::t_cmd  w_cmd;
    svap_pkg::t_stat w_stat;

    assign pready = 1'b1;

    svap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    svap_dp #(
        .NUM_VOICES  (NUM_VOICES),
        .NUM_EFFECTS (NUM_EFFECTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (psel && penable && pwrite),
        .i_cfg_idx     (paddr[3:2]),
        .i_cfg_wdata   (pwdata),
        .o_cfg_rdata   (prdata),
        .i_req_type    (i_req_type),
        .i_sfx_index   (i_sfx_index),
        .i_tag         (i_tag),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_base_volume (i_base_volume),
        .i_voice_in    (i_voice_in),
        .i_key_state   (i_key_state),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_voice_out   (o_voice_out),
        .o_vol_left    (o_vol_left),
        .o_vol_right   (o_vol_right),
        .o_vol_valid   (o_vol_valid),
        .o_key_on      (o_key_on),
        .o_key_off     (o_key_off),
        .o_reverb_on   (o_reverb_on),
        .o_note_down   (o_note_down),
        .o_sfx_out     (o_sfx_out)
    );

endmodule

>>> sv/svap_ctrl.sv
// sequencer for the voice allocator: walks items through the scan, scale,
// squaring, square root and divide steps of svap_dp; depends on svap_pkg
`timescale 1ns / 1ps

module svap_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  svap_pkg::t_stat i_stat,
    output svap_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    svap_pkg::t_state r_state, n_state;
    logic [4:0]       r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svap_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd.op  = svap_pkg::OP_NONE;
        o_cmd.sel = r_cnt[1:0];
        case (r_state)
            svap_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = svap_pkg::OP_LOAD;
                    n_state  = svap_pkg::S_DISP;
                end
            end
            svap_pkg::S_DISP: begin
                case (i_stat.req)
                    svap_pkg::REQ_PLAY:
                        n_state = i_stat.bad ? svap_pkg::S_FIN : svap_pkg::S_SCALE1;
                    svap_pkg::REQ_KEY:
                        n_state = svap_pkg::S_FIN;
                    default:
                        n_state = svap_pkg::S_SCAN;
                endcase
            end
            svap_pkg::S_SCALE1: begin
                o_cmd.op = svap_pkg::OP_SCALE1;
                n_state  = svap_pkg::S_SCALE2;
            end
            svap_pkg::S_SCALE2: begin
                o_cmd.op = svap_pkg::OP_SCALE2;
                n_cnt    = '0;
                n_state  = svap_pkg::S_SQ;
            end
            svap_pkg::S_SCAN: begin
                o_cmd.op = svap_pkg::OP_SCAN;
                if (i_stat.match) begin
                    n_state = (i_stat.req == svap_pkg::REQ_PAN) ? svap_pkg::S_LEVEL
                                                                : svap_pkg::S_FIN;
                end else if (i_stat.scan_last) begin
                    n_state = svap_pkg::S_FIN;
                end
            end
            svap_pkg::S_LEVEL: begin
                o_cmd.op = svap_pkg::OP_LEVEL;
                n_cnt    = '0;
                n_state  = svap_pkg::S_SQ;
            end
            svap_pkg::S_SQ: begin
                o_cmd.op = svap_pkg::OP_SQ;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == svap_pkg::SQ_STEPS - 5'd1) begin
                    n_cnt   = '0;
                    n_state = svap_pkg::S_ROOT;
                end
            end
            svap_pkg::S_ROOT: begin
                o_cmd.op = svap_pkg::OP_ROOT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == svap_pkg::ROOT_STEPS - 5'd1) begin
                    n_cnt   = '0;
                    n_state = svap_pkg::S_PAN;
                end
            end
            svap_pkg::S_PAN: begin
                o_cmd.op = svap_pkg::OP_PAN;
                n_state  = svap_pkg::S_MUL;
            end
            svap_pkg::S_MUL: begin
                o_cmd.op = svap_pkg::OP_MUL;
                n_cnt    = '0;
                n_state  = i_stat.p_zero ? svap_pkg::S_FIN : svap_pkg::S_DIV;
            end
            svap_pkg::S_DIV: begin
                o_cmd.op = svap_pkg::OP_DIV;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == svap_pkg::DIV_STEPS - 5'd1) begin
                    n_cnt   = '0;
                    n_state = svap_pkg::S_FIN;
                end
            end
            svap_pkg::S_FIN: begin
                o_cmd.op = svap_pkg::OP_FINISH;
                n_state  = svap_pkg::S_IDLE;
            end
            default: n_state = svap_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != svap_pkg::S_IDLE);

endmodule

>>> sv/svap_dp.sv
// datapath of the voice allocator: voice table, config registers, squaring,
// bit-pair square root, restoring divider and result registers; uses svap_pkg
`timescale 1ns / 1ps

module svap_dp #(
    parameter int NUM_VOICES  = 24,
    parameter int NUM_EFFECTS = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svap_pkg::t_cmd  i_cmd,
    output svap_pkg::t_stat o_stat,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_wdata,
    output logic [31:0]     o_cfg_rdata,
    input  logic [1:0]      i_req_type,
    input  logic [6:0]      i_sfx_index,
    input  logic [15:0]     i_tag,
    input  logic [15:0]     i_dir_x,
    input  logic [15:0]     i_dir_y,
    input  logic [15:0]     i_dir_z,
    input  logic [13:0]     i_base_volume,
    input  logic [4:0]      i_voice_in,
    input  logic [1:0]      i_key_state,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [4:0]      o_voice_out,
    output logic [14:0]     o_vol_left,
    output logic [14:0]     o_vol_right,
    output logic            o_vol_valid,
    output logic            o_key_on,
    output logic            o_key_off,
    output logic            o_reverb_on,
    output logic            o_note_down,
    output logic [6:0]      o_sfx_out
);

    localparam int VW = $clog2(NUM_VOICES);

    // configuration
    logic [3:0]  r_sfx_vol;
    logic        r_swap;
    logic        r_reverb;

    // voice table
    logic [NUM_VOICES-1:0] r_busy;
    logic [15:0]           r_vtag   [NUM_VOICES];
    logic [13:0]           r_level  [NUM_VOICES];
    logic [6:0]            r_effect [NUM_VOICES];

    // latched item
    svap_pkg::t_req r_req;
    logic [6:0]     r_sfx;
    logic [15:0]    r_tag;
    logic [15:0]    r_x, r_y, r_z;
    logic [13:0]    r_bvol;
    logic [4:0]     r_vin;
    logic [1:0]     r_ks;
    logic           r_eff_bad, r_no_free, r_vin_bad, r_found;
    logic [VW-1:0]  r_idx;

    // arithmetic
    logic [17:0] r_prod;
    logic [13:0] r_v;
    logic [31:0] r_sum;
    logic [31:0] r_root;
    logic [31:0] r_bit;
    logic [13:0] r_p;
    logic [13:0] r_d;
    logic [29:0] r_num;
    logic [14:0] r_drem;

    logic        r_valid;
    logic [1:0]  r_status;
    logic [4:0]  r_vout;
    logic [14:0] r_left, r_right;
    logic        r_volv, r_kon, r_koff, r_rvb, r_note;
    logic [6:0]  r_sfx_out;

    function automatic logic [14:0] sat15(input logic signed [31:0] v);
        if (v < 0) begin
            sat15 = '0;
        end else if (v > 32'sd32767) begin
            sat15 = 15'h7fff;
        end else begin
            sat15 = v[14:0];
        end
    endfunction

    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic signed [16:0] s;
        s = {v[15], v};
        mag16 = (s < 0) ? 17'(-s) : 17'(s);
    endfunction

    // lowest free voice
    logic [VW-1:0] w_free_idx;
    always_comb begin
        w_free_idx = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                w_free_idx = VW'(i);
            end
        end
    end

    logic [3:0]  w_sv;
    logic [35:0] w_scaled;
    logic [15:0] w_sel;
    logic [16:0] w_mag;
    logic [33:0] w_sq;
    logic [31:0] w_trial;
    logic [17:0] w_p3;
    logic [13:0] w_p;
    logic [16:0] w_xmag;
    logic [30:0] w_num;
    logic [14:0] w_rs;
    logic        w_ge;
    logic signed [31:0] w_q, w_t, w_a, w_b, w_ha, w_hb;
    logic        w_match;

    always_comb begin
        w_sv     = (r_sfx_vol > svap_pkg::SFX_VOL_MAX) ? svap_pkg::SFX_VOL_MAX : r_sfx_vol;
        w_scaled = 36'(r_prod) * svap_pkg::RECIP12;
        case (i_cmd.sel)
            2'd0:    w_sel = r_x;
            2'd1:    w_sel = r_y;
            default: w_sel = r_z;
        endcase
        w_mag   = mag16(w_sel);
        w_sq    = 34'(w_mag) * 34'(w_mag);
        w_trial = r_root + r_bit;
        w_p3    = 18'(r_root[16:0]) * 18'd3;
        w_p     = (w_p3 > {4'b0, r_v}) ? r_v : w_p3[13:0];
        w_xmag  = mag16(r_x);
        w_num   = 31'(w_xmag) * 31'(r_d);
        w_rs    = {r_drem[13:0], r_num[29]};
        w_ge    = (w_rs >= {1'b0, r_p});
        w_q     = 32'(r_num);
        w_t     = r_x[15] ? -w_q : w_q;
        w_a     = $signed({18'b0, r_d}) + w_t;
        w_b     = $signed({18'b0, r_d}) - w_t;
        w_ha    = (w_a < 0) ? 32'sd0 : (w_a >>> 1);
        w_hb    = (w_b < 0) ? 32'sd0 : (w_b >>> 1);
        w_match = r_busy[r_idx] && (r_vtag[r_idx] == r_tag);
    end

    always_comb begin
        o_stat.req       = r_req;
        o_stat.bad       = r_eff_bad || r_no_free;
        o_stat.match     = w_match;
        o_stat.scan_last = (32'(r_idx) == NUM_VOICES - 1);
        o_stat.p_zero    = (r_p == '0);
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfx_vol <= svap_pkg::SFX_VOL_RST;
            r_swap    <= 1'b0;
            r_reverb  <= 1'b0;
        end else if (i_cfg_we) begin
            case (svap_pkg::t_reg'(i_cfg_idx))
                svap_pkg::REG_SFX_VOL: r_sfx_vol <= i_cfg_wdata[3:0];
                svap_pkg::REG_SWAP:    r_swap    <= i_cfg_wdata[0];
                svap_pkg::REG_REVERB:  r_reverb  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (svap_pkg::t_reg'(i_cfg_idx))
            svap_pkg::REG_SFX_VOL: o_cfg_rdata = {28'b0, r_sfx_vol};
            svap_pkg::REG_SWAP:    o_cfg_rdata = {31'b0, r_swap};
            svap_pkg::REG_REVERB:  o_cfg_rdata = {31'b0, r_reverb};
            default:               o_cfg_rdata = '0;
        endcase
    end

    // item registers and arithmetic steps
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            svap_pkg::OP_LOAD: begin
                r_req     <= svap_pkg::t_req'(i_req_type);
                r_sfx     <= i_sfx_index;
                r_tag     <= i_tag;
                r_x       <= i_dir_x;
                r_y       <= i_dir_y;
                r_z       <= i_dir_z;
                r_bvol    <= i_base_volume;
                r_vin     <= i_voice_in;
                r_ks      <= i_key_state;
                r_eff_bad <= ({2'b0, i_sfx_index} >= 9'(NUM_EFFECTS));
                r_no_free <= &r_busy;
                r_vin_bad <= ({1'b0, i_voice_in} >= 6'(NUM_VOICES));
                r_found   <= 1'b0;
                r_sum     <= '0;
                r_root    <= '0;
                r_bit     <= svap_pkg::ROOT_BIT0;
                case (svap_pkg::t_req'(i_req_type))
                    svap_pkg::REQ_PLAY: r_idx <= w_free_idx;
                    svap_pkg::REQ_KEY:  r_idx <= i_voice_in[VW-1:0];
                    default:            r_idx <= '0;
                endcase
            end
            svap_pkg::OP_SCALE1: r_prod <= 18'(r_bvol) * 18'(w_sv);
            svap_pkg::OP_SCALE2: r_v <= w_scaled[svap_pkg::RECIP_SH +: 14];
            svap_pkg::OP_SCAN: begin
                if (w_match) begin
                    r_found <= 1'b1;
                end else if (32'(r_idx) != NUM_VOICES - 1) begin
                    r_idx <= r_idx + VW'(1);
                end
            end
            svap_pkg::OP_LEVEL: r_v <= r_level[r_idx];
            svap_pkg::OP_SQ:    r_sum <= r_sum + w_sq[31:0];
            svap_pkg::OP_ROOT: begin
                if (r_sum >= w_trial) begin
                    r_sum  <= r_sum - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            svap_pkg::OP_PAN: begin
                r_p <= w_p;
                r_d <= r_v - w_p;
            end
            svap_pkg::OP_MUL: begin
                r_num  <= w_num[29:0];
                r_drem <= '0;
            end
            svap_pkg::OP_DIV: begin
                r_drem <= w_ge ? (w_rs - {1'b0, r_p}) : w_rs;
                r_num  <= {r_num[28:0], w_ge};
            end
            default: ;
        endcase
    end

    // voice table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_vtag[i] <= '0;
            end
        end else if (i_cmd.op == svap_pkg::OP_FINISH) begin
            case (r_req)
                svap_pkg::REQ_PLAY: begin
                    if (!r_eff_bad && !r_no_free) begin
                        r_busy[r_idx] <= 1'b1;
                        r_vtag[r_idx] <= r_tag;
                    end
                end
                svap_pkg::REQ_KEY: begin
                    if (!r_vin_bad && (r_ks == svap_pkg::KS_OFF ||
                                       r_ks == svap_pkg::KS_OFF_ENV_ON)) begin
                        r_busy[r_idx] <= 1'b0;
                        r_vtag[r_idx] <= '0;
                    end
                end
                svap_pkg::REQ_MUTE: begin
                    if (r_found) begin
                        r_busy[r_idx] <= 1'b0;
                        r_vtag[r_idx] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == svap_pkg::OP_FINISH && r_req == svap_pkg::REQ_PLAY &&
            !r_eff_bad && !r_no_free) begin
            r_level[r_idx]  <= r_v;
            r_effect[r_idx] <= r_sfx;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == svap_pkg::OP_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == svap_pkg::OP_FINISH) begin
            r_status  <= svap_pkg::ST_DONE;
            r_vout    <= '0;
            r_left    <= '0;
            r_right   <= '0;
            r_volv    <= 1'b0;
            r_kon     <= 1'b0;
            r_koff    <= 1'b0;
            r_rvb     <= 1'b0;
            r_note    <= 1'b0;
            r_sfx_out <= '0;
            case (r_req)
                svap_pkg::REQ_PLAY: begin
                    if (r_eff_bad) begin
                        r_status <= svap_pkg::ST_NO_ACT;
                    end else if (r_no_free) begin
                        r_status <= svap_pkg::ST_NO_FREE;
                    end else begin
                        r_vout <= 5'(r_idx);
                        if (r_p == '0) begin
                            r_left  <= {1'b0, r_v};
                            r_right <= {1'b0, r_v};
                        end else begin
                            r_left  <= sat15(r_swap ? w_a : w_b);
                            r_right <= sat15(r_swap ? w_b : w_a);
                        end
                        r_volv    <= 1'b1;
                        r_kon     <= 1'b1;
                        r_rvb     <= r_reverb;
                        r_note    <= (r_tag > svap_pkg::TAG_LOW);
                        r_sfx_out <= r_sfx;
                    end
                end
                svap_pkg::REQ_KEY: begin
                    if (r_vin_bad) begin
                        r_status <= svap_pkg::ST_NO_ACT;
                    end else begin
                        r_vout    <= r_vin;
                        r_sfx_out <= r_busy[r_idx] ? r_effect[r_idx] : '0;
                        case (svap_pkg::t_key_state'(r_ks))
                            svap_pkg::KS_ON:         r_status <= svap_pkg::ST_NO_ACT;
                            svap_pkg::KS_ON_ENV_OFF: r_koff   <= 1'b1;
                            svap_pkg::KS_OFF_ENV_ON: r_volv   <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                default: begin
                    if (!r_found) begin
                        r_status <= svap_pkg::ST_NOT_FND;
                    end else begin
                        r_vout    <= 5'(r_idx);
                        r_sfx_out <= r_effect[r_idx];
                        if (r_req == svap_pkg::REQ_PAN) begin
                            r_volv <= 1'b1;
                            if (r_p == '0) begin
                                r_left  <= {2'b0, r_v[13:1]};
                                r_right <= {2'b0, r_v[13:1]};
                            end else begin
                                r_left  <= sat15(w_hb);
                                r_right <= sat15(w_ha);
                            end
                        end else begin
                            r_koff <= 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_voice_out = r_vout;
    assign o_vol_left  = r_left;
    assign o_vol_right = r_right;
    assign o_vol_valid = r_volv;
    assign o_key_on    = r_kon;
    assign o_key_off   = r_koff;
    assign o_reverb_on = r_rvb;
    assign o_note_down = r_note;
    assign o_sfx_out   = r_sfx_out;

endmodule
